/* rtl/bezpe_pkg.sv */
package bezpe_pkg;

  localparam int unsigned MAX_POINTS = 8;
  localparam int unsigned PtW        = $clog2(MAX_POINTS);
  localparam int unsigned IdxW       = 3;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned ParamW     = 17;
  localparam int unsigned OutW       = 24;
  localparam int unsigned CntW       = 4;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;

  localparam int unsigned MulW     = ParamW;
  localparam int unsigned LimbW    = 32;
  localparam int unsigned Limbs    = (CoordW * MAX_POINTS + LimbW - 1) / LimbW;
  localparam int unsigned LimbIdxW = $clog2(Limbs);
  localparam int unsigned BigW     = Limbs * LimbW;
  localparam int unsigned ProdW    = LimbW + MulW;
  localparam int unsigned SumW     = ProdW + 1;
  localparam int unsigned CarryW   = SumW - LimbW;
  localparam int unsigned ShW      = $clog2(BigW);

  localparam logic [ParamW-1:0] OneQ16   = ParamW'(65536);
  localparam logic [CntW-1:0]   PcReset  = CntW'(3);
  localparam logic              RegPointCount = 1'b0;

  // Multiply passes run for each control point after the first.
  typedef enum logic [2:0] {
    PASS_QT,
    PASS_CQ,
    PASS_XU,
    PASS_XA,
    PASS_YU,
    PASS_YA
  } pass_e;

  typedef struct packed {
    logic                valid;
    logic                first;
    logic [LimbIdxW-1:0] limb;
    pass_e               pass;
  } mac_ctl_t;

  typedef logic [MAX_POINTS-1:0][MulW-1:0] binom_row_t;
  typedef binom_row_t [MAX_POINTS-1:0]     binom_tab_t;

  function automatic binom_tab_t binom_build();
    binom_tab_t tab;
    int         r;
    int         c;
    for (r = 0; r < int'(MAX_POINTS); r++) begin
      for (c = 0; c < int'(MAX_POINTS); c++) begin
        if (c == 0) begin
          tab[r][c] = MulW'(1);
        end else if (r == 0) begin
          tab[r][c] = '0;
        end else begin
          tab[r][c] = tab[r-1][c-1] + tab[r-1][c];
        end
      end
    end
    return tab;
  endfunction

  localparam binom_tab_t BinomTab = binom_build();

endpackage

/* rtl/bezpe_cfg.sv */
module bezpe_cfg import bezpe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output logic [CntW-1:0]  point_count_o
);

  logic [CntW-1:0] point_count_q;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[AddrW-1] == RegPointCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= PcReset;
    end else if (wr_en) begin
      point_count_q <= pwdata[CntW-1:0];
    end
  end

  assign prdata = (paddr[AddrW-1] == RegPointCount) ? DataW'(point_count_q) : '0;
  assign point_count_o = point_count_q;

endmodule

/* rtl/bezpe_store.sv */
module bezpe_store import bezpe_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [PtW-1:0]    wr_idx_i,
  input  logic [CoordW-1:0] wr_x_i,
  input  logic [CoordW-1:0] wr_y_i,
  input  logic [PtW-1:0]    rd_idx_i,
  output logic [CoordW-1:0] rd_x_o,
  output logic [CoordW-1:0] rd_y_o
);

  logic [CoordW-1:0] ctrl_x_q [MAX_POINTS];
  logic [CoordW-1:0] ctrl_y_q [MAX_POINTS];
  logic [CoordW-1:0] rd_x_q;
  logic [CoordW-1:0] rd_y_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ctrl_x_q[wr_idx_i] <= wr_x_i;
      ctrl_y_q[wr_idx_i] <= wr_y_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_x_q <= ctrl_x_q[rd_idx_i];
    rd_y_q <= ctrl_y_q[rd_idx_i];
  end

  assign rd_x_o = rd_x_q;
  assign rd_y_o = rd_y_q;

endmodule

/* rtl/bezpe_mac.sv */
module bezpe_mac import bezpe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mac_ctl_t         issue_i,
  input  logic [LimbW-1:0] a_limb_i,
  input  logic [MulW-1:0]  m_i,
  input  logic [LimbW-1:0] b_limb_i,
  output mac_ctl_t         wr_o,
  output logic [LimbW-1:0] res_limb_o
);

  // The product of one limb is registered; the next cycle adds the addend limb
  // and the carry from the limb below.
  mac_ctl_t          ctl_q;
  logic [ProdW-1:0]  prod_q;
  logic [CarryW-1:0] carry_q;
  logic [CarryW-1:0] carry_in;
  logic [SumW-1:0]   sum;

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(a_limb_i) * ProdW'(m_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{valid: 1'b0, first: 1'b0, limb: '0, pass: PASS_QT};
    end else begin
      ctl_q <= issue_i;
    end
  end

  assign carry_in = ctl_q.first ? '0 : carry_q;
  assign sum      = SumW'(prod_q) + SumW'(b_limb_i) + SumW'(carry_in);

  always_ff @(posedge clk_i) begin
    if (ctl_q.valid) begin
      carry_q <= sum[SumW-1:LimbW];
    end
  end

  assign wr_o       = ctl_q;
  assign res_limb_o = sum[LimbW-1:0];

endmodule

/* rtl/bezier_point_evaluator.sv */
// An evaluation accepted at one clock edge gives its result on done_o for one cycle,
// once the passes for every point of the point count in use have run.
// busy stays high until the result cycle, so no new evaluation or load is accepted before then.
// Each further control point costs six passes of four limbs through the 32x17 multiplier.
// A load takes effect at its accepting edge and never raises busy.
// Reset clears the sequencer and sets the point count to three; control points keep no reset.
module bezier_point_evaluator import bezpe_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    op_i,
  input  logic [IdxW-1:0]         point_index_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic [ParamW-1:0]       param_t_i,
  output logic                    done_o,
  output logic signed [OutW-1:0]  curve_x_o,
  output logic signed [OutW-1:0]  curve_y_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrW-1:0]        paddr,
  input  logic [DataW-1:0]        pwdata,
  output logic [DataW-1:0]        prdata,
  output logic                    pready
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StInit  = 3'd1;
  localparam logic [2:0] StPass  = 3'd2;
  localparam logic [2:0] StDrain = 3'd3;
  localparam logic [2:0] StFinal = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [PtW-1:0]      pt_q, pt_d;
  logic [PtW-1:0]      deg_q, deg_d;
  pass_e               pass_q, pass_d;
  logic [LimbIdxW-1:0] iss_q, iss_d;
  logic [ParamW-1:0]   t_q, u_q;
  logic                done_q;
  logic [OutW-1:0]     curve_x_q, curve_y_q;

  logic [BigW-1:0] pw_q, cq_q, sx_q, sy_q;

  logic [CntW-1:0]   point_count;
  logic [CntW:0]     cnt_clamped;
  logic [ParamW-1:0] t_clamped;
  logic              accept, eval_go, load_go;
  logic [CoordW-1:0] rd_x, rd_y;
  logic [CoordW-1:0] off_x, off_y;

  mac_ctl_t          mac_issue, mac_wr;
  logic [LimbW-1:0]  a_limb, b_limb, res_limb;
  logic [MulW-1:0]   mul_m;

  bezpe_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .point_count_o (point_count)
  );

  assign busy    = (state_q != StIdle);
  assign accept  = start && !busy;
  assign eval_go = accept && op_i;
  assign load_go = accept && !op_i && (32'(point_index_i) < MAX_POINTS);

  // The store reads at the next point index, so its output follows the current point.
  bezpe_store u_store (
    .clk_i    (clk_i),
    .we_i     (load_go),
    .wr_idx_i (PtW'(point_index_i)),
    .wr_x_i   (point_x_i),
    .wr_y_i   (point_y_i),
    .rd_idx_i (pt_d),
    .rd_x_o   (rd_x),
    .rd_y_o   (rd_y)
  );

  // Points are taken in offset binary so that every product stays unsigned.
  assign off_x = {~rd_x[CoordW-1], rd_x[CoordW-2:0]};
  assign off_y = {~rd_y[CoordW-1], rd_y[CoordW-2:0]};

  always_comb begin
    if ({1'b0, point_count} < (CntW+1)'(2)) begin
      cnt_clamped = (CntW+1)'(2);
    end else if ({1'b0, point_count} > (CntW+1)'(MAX_POINTS)) begin
      cnt_clamped = (CntW+1)'(MAX_POINTS);
    end else begin
      cnt_clamped = {1'b0, point_count};
    end
    t_clamped = (param_t_i > OneQ16) ? OneQ16 : param_t_i;
  end

  always_comb begin
    state_d = state_q;
    pt_d    = pt_q;
    deg_d   = deg_q;
    pass_d  = pass_q;
    iss_d   = iss_q;
    unique case (state_q)
      StIdle: begin
        if (eval_go) begin
          state_d = StInit;
          pt_d    = '0;
          deg_d   = PtW'(cnt_clamped - (CntW+1)'(1));
        end
      end
      StInit: begin
        state_d = StPass;
        pt_d    = PtW'(1);
        pass_d  = PASS_QT;
        iss_d   = '0;
      end
      StPass: begin
        if (iss_q == LimbIdxW'(Limbs - 1)) begin
          iss_d = '0;
          unique case (pass_q)
            PASS_QT: pass_d = PASS_CQ;
            PASS_CQ: pass_d = PASS_XU;
            PASS_XU: pass_d = PASS_XA;
            PASS_XA: pass_d = PASS_YU;
            PASS_YU: pass_d = PASS_YA;
            PASS_YA: begin
              pass_d = PASS_QT;
              if (pt_q == deg_q) begin
                state_d = StDrain;
              end else begin
                pt_d = pt_q + PtW'(1);
              end
            end
            default: pass_d = PASS_QT;
          endcase
        end else begin
          iss_d = iss_q + LimbIdxW'(1);
        end
      end
      StDrain: state_d = StFinal;
      StFinal: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pt_q    <= '0;
      deg_q   <= '0;
      pass_q  <= PASS_QT;
      iss_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pt_q    <= pt_d;
      deg_q   <= deg_d;
      pass_q  <= pass_d;
      iss_q   <= iss_d;
      done_q  <= (state_q == StFinal);
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_go) begin
      t_q <= t_clamped;
      u_q <= OneQ16 - t_clamped;
    end
  end

  assign mac_issue = '{valid: (state_q == StPass), first: (iss_q == '0), limb: iss_q,
                       pass: pass_q};

  always_comb begin
    unique case (pass_q)
      PASS_QT: begin
        a_limb = pw_q[iss_q*LimbW +: LimbW];
        mul_m  = t_q;
      end
      PASS_CQ: begin
        a_limb = pw_q[iss_q*LimbW +: LimbW];
        mul_m  = BinomTab[deg_q][pt_q];
      end
      PASS_XU: begin
        a_limb = sx_q[iss_q*LimbW +: LimbW];
        mul_m  = u_q;
      end
      PASS_XA: begin
        a_limb = cq_q[iss_q*LimbW +: LimbW];
        mul_m  = MulW'(off_x);
      end
      PASS_YU: begin
        a_limb = sy_q[iss_q*LimbW +: LimbW];
        mul_m  = u_q;
      end
      PASS_YA: begin
        a_limb = cq_q[iss_q*LimbW +: LimbW];
        mul_m  = MulW'(off_y);
      end
      default: begin
        a_limb = '0;
        mul_m  = '0;
      end
    endcase
  end

  always_comb begin
    unique case (mac_wr.pass)
      PASS_XA: b_limb = sx_q[mac_wr.limb*LimbW +: LimbW];
      PASS_YA: b_limb = sy_q[mac_wr.limb*LimbW +: LimbW];
      default: b_limb = '0;
    endcase
  end

  bezpe_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .issue_i    (mac_issue),
    .a_limb_i   (a_limb),
    .m_i        (mul_m),
    .b_limb_i   (b_limb),
    .wr_o       (mac_wr),
    .res_limb_o (res_limb)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == StInit) begin
      pw_q <= BigW'(1);
      sx_q <= BigW'(off_x);
      sy_q <= BigW'(off_y);
    end else if (mac_wr.valid) begin
      unique case (mac_wr.pass)
        PASS_QT:           pw_q[mac_wr.limb*LimbW +: LimbW] <= res_limb;
        PASS_CQ:           cq_q[mac_wr.limb*LimbW +: LimbW] <= res_limb;
        PASS_XU, PASS_XA:  sx_q[mac_wr.limb*LimbW +: LimbW] <= res_limb;
        PASS_YU, PASS_YA:  sy_q[mac_wr.limb*LimbW +: LimbW] <= res_limb;
        default:           pw_q <= pw_q;
      endcase
    end
  end

  // The exact sum carries 16 fraction bits per degree; keep eight and round to nearest.
  function automatic logic [OutW-1:0] round_coord(logic [BigW-1:0] s, logic [PtW-1:0] deg);
    logic [ShW-1:0]  amt;
    logic [BigW-1:0] sh;
    logic [OutW-1:0] q;
    amt = ShW'({deg, 4'b0000}) - ShW'(9);
    sh  = s >> amt;
    q   = sh[OutW:1] + OutW'(sh[0]);
    return {~q[OutW-1], q[OutW-2:0]};
  endfunction

  always_ff @(posedge clk_i) begin
    if (state_q == StFinal) begin
      curve_x_q <= round_coord(sx_q, deg_q);
      curve_y_q <= round_coord(sy_q, deg_q);
    end
  end

  assign done_o    = done_q;
  assign curve_x_o = curve_x_q;
  assign curve_y_o = curve_y_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("Result strobe raised while an evaluation is still running.");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i) |=> (busy && !done_o))
    else $error("Accepted evaluation did not start the sequencer.");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !op_i) |=> (!busy && !done_o))
    else $error("Accepted load started the sequencer or produced a result.");

  a_point_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (pt_q <= deg_q))
    else $error("Point counter ran beyond the curve degree.");

  a_limb_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_wr.valid |-> (busy && (mac_wr.first == (mac_wr.limb == '0))))
    else $error("Limb write out of order or outside an evaluation.");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import bezpe_pkg::*;

  localparam logic          OpLoad         = 1'b0;
  localparam logic          OpEval         = 1'b1;
  localparam logic [AddrW-1:0] PointCountAddr = AddrW'(4 * RegPointCount);
  localparam int unsigned   RandomItems    = 1600;
  localparam int unsigned   IdleLimit      = 2000;
  localparam int unsigned   DrainCycles    = 24 * (MAX_POINTS - 1) + 8;

  typedef logic [CoordW-1:0] ctrl_store_t [MAX_POINTS];

  typedef struct {
    logic signed [OutW-1:0] x;
    logic signed [OutW-1:0] y;
  } curve_point_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic                     op_i;
  logic [IdxW-1:0]          point_index_i;
  logic signed [CoordW-1:0] point_x_i;
  logic signed [CoordW-1:0] point_y_i;
  logic [ParamW-1:0]        param_t_i;
  logic                     done_o;
  logic signed [OutW-1:0]   curve_x_o;
  logic signed [OutW-1:0]   curve_y_o;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [AddrW-1:0]         paddr;
  logic [DataW-1:0]         pwdata;
  logic [DataW-1:0]         prdata;
  logic                     pready;

  ctrl_store_t    ctrl_x;
  ctrl_store_t    ctrl_y;
  logic [CntW-1:0] point_count_reg;
  curve_point_t   curve_queue [$];
  int unsigned    error_count;
  int unsigned    load_count;
  int unsigned    eval_count;
  int unsigned    result_count;
  int unsigned    config_count;
  int unsigned    random_sent;
  int unsigned    idle_cycles;
  logic [15:0]    counts_seen;
  bit             no_gap_mode;

  bezier_point_evaluator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .point_index_i (point_index_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .param_t_i     (param_t_i),
    .done_o        (done_o),
    .curve_x_o     (curve_x_o),
    .curve_y_o     (curve_y_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic logic [OutW-1:0] bezier_coord(input ctrl_store_t pts, input int unsigned d,
                                                   input logic [ParamW-1:0] t);
    logic [191:0]      acc;
    logic [191:0]      w;
    logic [ParamW-1:0] u;
    logic [31:0]       q;
    int unsigned       binom;
    int unsigned       k;
    acc   = '0;
    binom = 1;
    u     = OneQ16 - t;
    for (int unsigned i = 0; i <= d; i++) begin
      w = 192'(binom);
      for (int unsigned e = 0; e < i; e++) w = w * t;
      for (int unsigned e = i; e < d; e++) w = w * u;
      w   = w * 192'(pts[i] ^ 16'h8000);
      acc = acc + w;
      if (i < d) binom = binom * (d - i) / (i + 1);
    end
    k   = 16 * d - 8;
    acc = acc + (192'(1) << (k - 1));
    q   = 32'(acc >> k);
    return q[OutW-1:0] ^ 24'h800000;
  endfunction

  function automatic curve_point_t curve_point_at(input logic [ParamW-1:0] t_raw);
    curve_point_t      p;
    int unsigned       n;
    logic [ParamW-1:0] t;
    n = point_count_reg;
    if (n < 2) n = 2;
    if (n > MAX_POINTS) n = MAX_POINTS;
    t   = (t_raw > OneQ16) ? OneQ16 : t_raw;
    p.x = bezier_coord(ctrl_x, n - 1, t);
    p.y = bezier_coord(ctrl_y, n - 1, t);
    return p;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gap_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [ParamW-1:0] pick_param();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return OneQ16;
      2: return ParamW'($urandom_range(65537, 131071));
      3: return ParamW'($urandom_range(0, 255));
      4: return OneQ16 - ParamW'($urandom_range(0, 255));
      default: return ParamW'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [CoordW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return CoordW'($urandom);
    endcase
  endfunction

  function automatic logic [CntW-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return CntW'($urandom_range(0, 15));
      1: return CntW'(2);
      2: return CntW'(MAX_POINTS);
      default: return CntW'($urandom_range(2, MAX_POINTS));
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [IdxW-1:0] idx,
                           input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                           input logic [ParamW-1:0] t);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    op_i          = op;
    point_index_i = idx;
    point_x_i     = x;
    point_y_i     = y;
    param_t_i     = t;
    start         = 1'b1;
    do @(posedge clk_i); while (busy);
    if (op == OpLoad) begin
      ctrl_x[idx] = x;
      ctrl_y[idx] = y;
      load_count++;
    end else begin
      curve_queue.push_back(curve_point_at(t));
      eval_count++;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start = 1'b0;
    while (curve_queue.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == PointCountAddr) point_count_reg = data[CntW-1:0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apb_read_check(input logic [AddrW-1:0] addr, input logic [CntW-1:0] want);
    logic [DataW-1:0] got;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    if (got[CntW-1:0] !== want) begin
      $error("point_count: expected %0d, got %0d", want, got[CntW-1:0]);
      error_count++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_point_count(input logic [CntW-1:0] value);
    wait_idle();
    apb_write(PointCountAddr, DataW'(value));
    apb_read_check(PointCountAddr, value);
    config_count++;
    counts_seen[value] = 1'b1;
  endtask

  task automatic test_register_reset();
    apb_read_check(PointCountAddr, PcReset);
    counts_seen[PcReset] = 1'b1;
  endtask

  task automatic test_control_extremes();
    for (int unsigned i = 0; i < MAX_POINTS; i++) begin
      send_item(OpLoad, IdxW'(i), (i % 2 == 0) ? 16'h8000 : 16'h7fff,
                (i % 2 == 0) ? 16'h7fff : 16'h8000, ParamW'(i));
    end
    send_item(OpEval, '0, '0, '0, '0);
    send_item(OpEval, '0, '0, '0, OneQ16);
    send_item(OpEval, '0, '0, '0, ParamW'(32768));
  endtask

  task automatic test_point_count_range();
    logic [CntW-1:0] counts [6];
    counts = '{CntW'(2), CntW'(MAX_POINTS), CntW'(0), CntW'(1), CntW'(9), CntW'(15)};
    foreach (counts[c]) begin
      set_point_count(counts[c]);
      send_item(OpEval, '0, '0, '0, (c % 2 == 0) ? ParamW'(131071) : ParamW'(1));
      send_item(OpEval, '0, '0, '0, ParamW'(65535));
    end
  endtask

  task automatic test_random_curves();
    int unsigned len;
    while (random_sent < RandomItems) begin
      set_point_count(pick_count());
      no_gap_mode = ($urandom_range(0, 3) == 0);
      len = $urandom_range(20, 60);
      repeat (len) begin
        if ($urandom_range(0, 9) < 4) begin
          send_item(OpLoad, IdxW'($urandom_range(0, MAX_POINTS - 1)), pick_coord(),
                    pick_coord(), ParamW'($urandom));
        end else begin
          send_item(OpEval, IdxW'($urandom), CoordW'($urandom), CoordW'($urandom),
                    pick_param());
        end
        random_sent++;
      end
    end
    no_gap_mode = 1'b0;
  endtask

  always @(posedge clk_i) begin
    curve_point_t want;
    if (rst_ni && done_o) begin
      result_count++;
      if (curve_queue.size() == 0) begin
        $error("curve point beat with no evaluation outstanding");
        error_count++;
      end else begin
        want = curve_queue.pop_front();
        if (curve_x_o !== want.x) begin
          $error("curve_x: expected %0d, got %0d", want.x, curve_x_o);
          error_count++;
        end
        if (curve_y_o !== want.y) begin
          $error("curve_y: expected %0d, got %0d", want.y, curve_y_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("bezier_point_evaluator test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    op_i            = OpLoad;
    point_index_i   = '0;
    point_x_i       = '0;
    point_y_i       = '0;
    param_t_i       = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    point_count_reg = PcReset;
    error_count     = 0;
    load_count      = 0;
    eval_count      = 0;
    result_count    = 0;
    config_count    = 0;
    random_sent     = 0;
    idle_cycles     = 0;
    counts_seen     = '0;
    no_gap_mode     = 1'b0;
    foreach (ctrl_x[i]) begin
      ctrl_x[i] = '0;
      ctrl_y[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_reset();
    test_control_extremes();
    test_point_count_range();
    test_random_curves();

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (curve_queue.size() != 0) begin
      $error("%0d curve points never returned", curve_queue.size());
      error_count++;
    end
    $display("Covered %0d control point loads and %0d evaluations, %0d results checked.",
             load_count, eval_count, result_count);
    $display("Point count written %0d times, settings used: %b.", config_count, counts_seen);
    if (error_count == 0) begin
      $display("bezier_point_evaluator test passed");
    end else begin
      $display("bezier_point_evaluator test failed");
    end
    $finish;
  end

endmodule
